// ===== hw/rtl/xbri_pkg.sv =====
// ----------------------------------------------------------------------------
// xbri_pkg
// Shared constants, types and the generator step function for the xorshift
// bounded random integer unit.
// ----------------------------------------------------------------------------
package xbri_pkg;

    localparam int MAX_TRIES = 100;
    localparam int TRY_W     = $clog2(MAX_TRIES + 1);

    localparam int MOD_STEPS = 64;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    localparam logic [63:0] SEED_FALLBACK = 64'h0000_C0FF_EEC0_FFEE;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAW,
        S_LIMIT,
        S_DRAW,
        S_REDUCE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic draw;
        logic mod_step;
        logic save_limit;
        logic load_draw;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_raw;
        logic req_empty;
        logic mod_last;
        logic draw_ok;
        logic tries_last;
    } t_sts;

    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

// ===== hw/rtl/xbri_ifs.sv =====
// ----------------------------------------------------------------------------
// xbri request and response channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface xbri_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;

    modport source (output valid, opcode, range_min, range_max, input ready);
    modport sink   (input valid, opcode, range_min, range_max, output ready);
endinterface

interface xbri_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_value;
    logic        [63:0] raw_value;
    logic               tries_exhausted;

    modport source (output valid, range_value, raw_value, tries_exhausted, input ready);
    modport sink   (input valid, range_value, raw_value, tries_exhausted, output ready);
endinterface

// ===== hw/rtl/xbri_ctrl.sv =====
// ----------------------------------------------------------------------------
// xbri_ctrl
// Sequencer: request capture, raw draws, limit reduction, rejection draws, final
// reduction and hand-off to the result register.
// ----------------------------------------------------------------------------
module xbri_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output xbri_pkg::t_cmd o_cmd,
    input  xbri_pkg::t_sts i_sts
);

    xbri_pkg::t_state r_state;
    xbri_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_slot_free;
    logic             w_accept;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xbri_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.req_raw)   n_state = xbri_pkg::S_RAW;
                    else if (i_sts.req_empty)     n_state = xbri_pkg::S_OUT;
                    else                          n_state = xbri_pkg::S_LIMIT;
                end
            end
            xbri_pkg::S_RAW:   n_state = xbri_pkg::S_OUT;
            xbri_pkg::S_LIMIT: begin
                if (i_sts.mod_last) n_state = xbri_pkg::S_DRAW;
            end
            xbri_pkg::S_DRAW: begin
                if (i_sts.draw_ok || i_sts.tries_last) n_state = xbri_pkg::S_REDUCE;
            end
            xbri_pkg::S_REDUCE: begin
                if (i_sts.mod_last) n_state = xbri_pkg::S_OUT;
            end
            xbri_pkg::S_OUT: begin
                if (w_slot_free) n_state = xbri_pkg::S_IDLE;
            end
            default: n_state = xbri_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            xbri_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            xbri_pkg::S_RAW: begin
                o_cmd.draw = 1'b1;
            end
            xbri_pkg::S_LIMIT: begin
                o_cmd.mod_step   = 1'b1;
                o_cmd.save_limit = i_sts.mod_last;
            end
            xbri_pkg::S_DRAW: begin
                o_cmd.draw      = 1'b1;
                o_cmd.load_draw = i_sts.draw_ok || i_sts.tries_last;
            end
            xbri_pkg::S_REDUCE: begin
                o_cmd.mod_step = 1'b1;
            end
            xbri_pkg::S_OUT: begin
                o_cmd.load_out = w_slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.load_out) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xbri_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // a full result register is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while still waiting");

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != xbri_pkg::S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // draws only happen in the draw states
    a_draw_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.draw |-> (r_state == xbri_pkg::S_RAW || r_state == xbri_pkg::S_DRAW))
        else $error("generator advanced outside a draw state");
`endif

endmodule

// ===== hw/rtl/xbri_dpath.sv =====
// ----------------------------------------------------------------------------
// xbri_dpath
// Generator state, bit-serial modulo unit, rejection limit, try counter and
// the result register.
// ----------------------------------------------------------------------------
module xbri_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seed_we,
    input  logic        [63:0] i_seed_wdata,
    input  logic               i_opcode,
    input  logic signed [31:0] i_range_min,
    input  logic signed [31:0] i_range_max,
    input  xbri_pkg::t_cmd     i_cmd,
    output xbri_pkg::t_sts     o_sts,
    output logic signed [31:0] o_range_value,
    output logic        [63:0] o_raw_value,
    output logic               o_tries_exhausted
);

    logic        [63:0]                r_gen;
    logic                              r_op;
    logic                              r_empty;
    logic        [31:0]                r_min;
    logic        [32:0]                r_span;
    logic        [63:0]                r_limit;
    logic        [63:0]                r_div;
    logic        [31:0]                r_rem;
    logic        [xbri_pkg::CNT_W-1:0] r_cnt;
    logic        [63:0]                r_draw;
    logic        [xbri_pkg::TRY_W-1:0] r_tries;
    logic                              r_exh;
    logic signed [31:0]                r_o_range;
    logic        [63:0]                r_o_raw;
    logic                              r_o_exh;

    logic [32:0] w_span;
    logic [32:0] w_trial;
    logic [31:0] n_rem;
    logic [63:0] w_gen_next;
    logic [63:0] w_draw_next;
    logic        w_draw_ok;

    assign w_span = {i_range_max[31], i_range_max} - {i_range_min[31], i_range_min} + 33'd1;

    // restoring step: shift in the next dividend bit, subtract span if it fits
    assign w_trial = {r_rem, r_div[63]};
    assign n_rem   = (w_trial >= r_span) ? 32'(w_trial - r_span) : w_trial[31:0];

    assign w_gen_next  = xbri_pkg::xorshift(r_gen);
    assign w_draw_next = w_gen_next - 64'd1;
    assign w_draw_ok   = w_draw_next <= r_limit;

    assign o_sts.req_raw    = i_opcode;
    assign o_sts.req_empty  = i_range_min >= i_range_max;
    assign o_sts.mod_last   = r_cnt == {xbri_pkg::CNT_W{1'b1}};
    assign o_sts.draw_ok    = w_draw_ok;
    assign o_sts.tries_last = r_tries == xbri_pkg::TRY_W'(xbri_pkg::MAX_TRIES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= xbri_pkg::SEED_FALLBACK;
        end else if (i_seed_we) begin
            r_gen <= (i_seed_wdata == 64'd0) ? xbri_pkg::SEED_FALLBACK : i_seed_wdata;
        end else if (i_cmd.draw) begin
            r_gen <= w_gen_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_empty <= i_range_min >= i_range_max;
            r_min   <= i_range_min;
            r_span  <= w_span;
            r_div   <= '1;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_tries <= '0;
            r_exh   <= 1'b0;
        end else begin
            if (i_cmd.mod_step) begin
                r_div <= r_div << 1;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.save_limit) begin
                r_limit <= 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, n_rem} - 64'd1;
            end
            if (i_cmd.draw) begin
                r_draw  <= w_draw_next;
                r_tries <= r_tries + 1'b1;
            end
            if (i_cmd.load_draw) begin
                r_div <= w_draw_next;
                r_rem <= '0;
                r_cnt <= '0;
                r_exh <= !w_draw_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            priority if (r_op) begin
                r_o_range <= '0;
                r_o_raw   <= r_draw;
                r_o_exh   <= 1'b0;
            end else if (r_empty) begin
                r_o_range <= r_min;
                r_o_raw   <= '0;
                r_o_exh   <= 1'b0;
            end else begin
                r_o_range <= r_min + r_rem;
                r_o_raw   <= r_draw;
                r_o_exh   <= r_exh;
            end
        end
    end

    assign o_range_value     = r_o_range;
    assign o_raw_value       = r_o_raw;
    assign o_tries_exhausted = r_o_exh;

`ifndef SYNTHESIS
    // xorshift never reaches the all-zero state
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != 64'd0)
        else $error("generator state is zero");

    // the running remainder stays below the span
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_step |-> ({1'b0, r_rem} < r_span))
        else $error("remainder not below span");

    // no more draws than the try budget
    a_try_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.draw && !r_op) |-> (r_tries < xbri_pkg::TRY_W'(xbri_pkg::MAX_TRIES)))
        else $error("try budget exceeded");
`endif

endmodule

// ===== hw/rtl/xorshift_bounded_random_integer_unit.sv =====
// Raw request: the draw state, then the output state, then the registered result.
// Empty range: output state only. Range request: 64 steps of limit reduction, N draws,
// 64 final reduction steps and the output state; one-bit-per-cycle modulo unit run twice.
// Throughput: one request at a time; the next is accepted while a result waits.
// Reset (synchronous, active low): generator state to 0xC0FFEEC0FFEE, idle, no result.
// ----------------------------------------------------------------------------
// xorshift_bounded_random_integer_unit
// 64-bit xorshift generator with rejection-sampled bounded integer output.
// ----------------------------------------------------------------------------
module xorshift_bounded_random_integer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed_wdata,
    xbri_req_if.sink    i_req,
    xbri_rsp_if.source  o_rsp
);

    xbri_pkg::t_cmd w_cmd;
    xbri_pkg::t_sts w_sts;

    xbri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    xbri_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_seed_we         (i_seed_we),
        .i_seed_wdata      (i_seed_wdata),
        .i_opcode          (i_req.opcode),
        .i_range_min       (i_req.range_min),
        .i_range_max       (i_req.range_max),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_range_value     (o_rsp.range_value),
        .o_raw_value       (o_rsp.raw_value),
        .o_tries_exhausted (o_rsp.tries_exhausted)
    );

endmodule

// ===== verif/xorshift_bounded_random_integer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// xorshift_bounded_random_integer_unit_tb
// Drives raw and bounded range requests through the valid/ready request
// channel and checks every result beat against a cycle-free predictor of the
// xorshift generator and its rejection sampling. The seed register is
// reloaded between phases while the unit is idle. Both sides idle at random.
// ----------------------------------------------------------------------------
module xorshift_bounded_random_integer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        OP_RANGE      = 1'b0;
    localparam logic        OP_RAW        = 1'b1;
    localparam logic [63:0] ZERO_SEED_SUB = 64'h0000_C0FF_EEC0_FFEE;
    localparam int          TRY_LIMIT     = 100;
    localparam int          SHL_FIRST     = 13;
    localparam int          SHR_SECOND    = 7;
    localparam int          SHL_THIRD     = 17;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          TAIL_CYCLES   = 400;
    localparam longint      CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic        opcode;
        logic [31:0] lo;
        logic [31:0] hi;
        int          gap;
        bit          drain;
    } draw_request_t;

    typedef struct {
        logic [31:0] value;
        logic [63:0] raw;
        logic        exhausted;
    } draw_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_seed_we;
    logic [63:0] i_seed_wdata;

    xbri_req_if req_bus ();
    xbri_rsp_if rsp_bus ();

    xorshift_bounded_random_integer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_req        (req_bus),
        .o_rsp        (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [63:0]   gen_state;
    draw_request_t pending_requests[$];
    draw_result_t  expected_draws[$];
    int            mismatch_count = 0;
    int            results_checked = 0;
    longint        cycle_count = 0;

    logic          req_beat = 1'b0;
    logic          rsp_beat = 1'b0;

    draw_request_t staged;
    bit            item_staged = 1'b0;
    int            gap_left = 0;

    int            results_taken = 0;
    int            stall_left = 0;
    int            hold_left = 0;

    // ------------------------------------------------------------------
    // Generator and predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] advance_generator();
        logic [63:0] s;
        s = gen_state;
        s = s ^ (s << SHL_FIRST);
        s = s ^ (s >> SHR_SECOND);
        s = s ^ (s << SHL_THIRD);
        gen_state = s;
        return s - 64'd1;
    endfunction

    function automatic draw_result_t predict_draw(input logic op, input logic [31:0] lo,
                                                  input logic [31:0] hi);
        draw_result_t r;
        logic [63:0]  lo64;
        logic [63:0]  hi64;
        logic [63:0]  span;
        logic [63:0]  limit;
        logic [63:0]  d;
        logic [63:0]  ofs;
        int           n;
        bit           ok;
        r.value     = '0;
        r.raw       = '0;
        r.exhausted = 1'b0;
        if (op == OP_RAW) begin
            r.raw = advance_generator();
        end else if ($signed(lo) >= $signed(hi)) begin
            // empty or inverted range leaves the generator alone
            r.value = lo;
        end else begin
            lo64  = {{32{lo[31]}}, lo};
            hi64  = {{32{hi[31]}}, hi};
            span  = hi64 - lo64 + 64'd1;
            limit = ({64{1'b1}} / span) * span - 64'd1;
            d     = '0;
            ok    = 1'b0;
            n     = 0;
            while (!ok && n < TRY_LIMIT) begin
                d  = advance_generator();
                ok = (d <= limit);
                n++;
            end
            ofs         = d % span;
            r.raw       = d;
            r.exhausted = !ok;
            r.value     = lo + ofs[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        $display("MISMATCH at result %0d: %s got 0x%h want 0x%h",
                 results_checked, what, got, want_v);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : req_driver
        logic offer;
        offer = req_bus.valid && !req_beat;
        if (i_rst_n && !offer) begin
            if (!item_staged && pending_requests.size() != 0) begin
                staged      = pending_requests.pop_front();
                item_staged = 1'b1;
                gap_left    = staged.gap;
            end
            if (item_staged) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!staged.drain || expected_draws.size() == 0) begin
                    offer       = 1'b1;
                    item_staged = 1'b0;
                    req_bus.opcode    <= staged.opcode;
                    req_bus.range_min <= staged.lo;
                    req_bus.range_max <= staged.hi;
                end
            end
        end
        req_bus.valid <= offer;
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls after each beat outside every fourth stretch of fifty, two long hold-offs
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : rsp_receiver
        logic rdy;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else begin
            if (rsp_beat) begin
                results_taken++;
                stall_left = (((results_taken / 50) % 4) == 2) ? 0 : $urandom_range(0, 16);
                if (results_taken == 40 || results_taken == 250)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
        end
        rsp_bus.ready <= rdy;
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        draw_result_t want;
        req_beat <= i_rst_n && req_bus.valid && req_bus.ready;
        rsp_beat <= i_rst_n && rsp_bus.valid && rsp_bus.ready;
        if (i_rst_n && req_bus.valid && req_bus.ready)
            expected_draws.push_back(predict_draw(req_bus.opcode, req_bus.range_min,
                                                  req_bus.range_max));
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected result, raw_value", rsp_bus.raw_value, '0);
            end else begin
                want = expected_draws.pop_front();
                if (rsp_bus.range_value !== want.value)
                    report_mismatch("range_value", {32'd0, rsp_bus.range_value},
                                    {32'd0, want.value});
                if (rsp_bus.raw_value !== want.raw)
                    report_mismatch("raw_value", rsp_bus.raw_value, want.raw);
                if (rsp_bus.tries_exhausted !== want.exhausted)
                    report_mismatch("tries_exhausted", {63'd0, rsp_bus.tries_exhausted},
                                    {63'd0, want.exhausted});
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("xorshift_bounded_random_integer_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_request(input logic op, input logic [31:0] lo, input logic [31:0] hi,
                                input int gap, input bit drain);
        draw_request_t r;
        r.opcode = op;
        r.lo     = lo;
        r.hi     = hi;
        r.gap    = gap;
        r.drain  = drain;
        pending_requests.push_back(r);
    endtask

    function automatic draw_request_t random_request(input bit no_gap);
        draw_request_t r;
        int unsigned   kind;
        r.opcode = ($urandom_range(0, 9) < 3) ? OP_RAW : OP_RANGE;
        r.lo     = $urandom;
        r.hi     = $urandom;
        kind     = $urandom_range(0, 9);
        if (r.opcode == OP_RANGE) begin
            case (kind)
                0, 1, 2, 3: r.hi = r.lo + $urandom_range(0, 1000);
                4: r.hi = r.lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
                5: r.hi = r.lo - $urandom_range(0, 1000);
                6: begin
                    r.lo = 32'h8000_0000 + $urandom_range(0, 3);
                    r.hi = 32'h7FFF_FFFF - $urandom_range(0, 3);
                end
                default: ;
            endcase
        end
        r.gap   = no_gap ? 0 : $urandom_range(0, 16);
        r.drain = ($urandom_range(0, 39) == 0);
        return r;
    endfunction

    // Hold until every queued request is sent and every result is back.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || item_staged || req_bus.valid ||
               expected_draws.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [63:0] v);
        @(negedge i_clk);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= v;
        gen_state = (v == 64'd0) ? ZERO_SEED_SUB : v;
        @(negedge i_clk);
        i_seed_we <= 1'b0;
    endtask

    initial begin
        logic [63:0] seed;
        int          p;
        int          i;
        i_rst_n           = 1'b0;
        i_seed_we         = 1'b0;
        i_seed_wdata      = '0;
        req_bus.valid     = 1'b0;
        req_bus.opcode    = OP_RANGE;
        req_bus.range_min = '0;
        req_bus.range_max = '0;
        rsp_bus.ready     = 1'b0;
        gen_state         = ZERO_SEED_SUB;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners under the reset seed
        push_request(OP_RAW,   32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        push_request(OP_RAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        push_request(OP_RANGE, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        push_request(OP_RANGE, 32'h0000_0005, 32'hFFFF_FFFB, 3, 1'b0);
        push_request(OP_RANGE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
        push_request(OP_RANGE, 32'h8000_0000, 32'h8000_0000, 0, 1'b0);
        push_request(OP_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1'b0);
        push_request(OP_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        push_request(OP_RANGE, 32'h0000_0000, 32'h0000_0001, 0, 1'b0);
        push_request(OP_RANGE, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 0, 1'b0);
        push_request(OP_RANGE, 32'h8000_0000, 32'h8000_0001, 2, 1'b0);
        push_request(OP_RANGE, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        push_request(OP_RANGE, 32'h0000_0000, 32'h0000_0002, 0, 1'b1);
        push_request(OP_RANGE, 32'hFFFF_FF9C, 32'h0000_0064, 0, 1'b0);
        push_request(OP_RANGE, 32'h0000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        push_request(OP_RANGE, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
        push_request(OP_RANGE, 32'h8000_0001, 32'h7FFF_FFFE, 0, 1'b0);
        push_request(OP_RAW,   32'h5555_5555, 32'hAAAA_AAAA, 5, 1'b0);

        for (p = 0; p < 5; p++) begin
            wait_idle();
            case (p)
                0:       seed = 64'd0;
                1:       seed = {64{1'b1}};
                2:       seed = 64'd1;
                default: seed = {$urandom, $urandom};
            endcase
            load_seed(seed);
            // every fourth stretch of twenty runs back to back
            for (i = 0; i < 80; i++)
                pending_requests.push_back(random_request(((i / 20) % 4) == 3));
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_draws.size() != 0)
            report_mismatch("results never arrived", '0, 64'(expected_draws.size()));
        if (mismatch_count == 0) begin
            $display("xorshift_bounded_random_integer_unit verification clean");
        end else begin
            $display("xorshift_bounded_random_integer_unit verification failed");
        end
        $finish;
    end

endmodule
